### sv/protobuf_field_tokenizer_macros.svh
// Assertion helpers shared by the tokenizer RTL.
`ifndef PROTOBUF_FIELD_TOKENIZER_MACROS_SVH
`define PROTOBUF_FIELD_TOKENIZER_MACROS_SVH

// Concurrent check on an explicit clock and reset.
`define PFT_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on the block's own clock and reset.
`define PFT_ASSERT(label, prop, msg) \
   `PFT_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

### sv/pft_pkg.sv
package pft_pkg;

   // Width of byte positions and payload offsets
   localparam int OffsetBits = 24;

   // Result queue depth; a byte pushes at most two results
   localparam int QueueDepth = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);

   // Wire types handled by the parser
   localparam logic [2:0] WT_VARINT = 3'd0;
   localparam logic [2:0] WT_FIX64  = 3'd1;
   localparam logic [2:0] WT_LEN    = 3'd2;
   localparam logic [2:0] WT_FIX32  = 3'd5;

   // Longest varint is ten groups; group index nine is the last
   localparam logic [3:0] VarintLastGroup = 4'd9;

   typedef enum logic [2:0] {
      PH_KEY,
      PH_VARVAL,
      PH_FIX64,
      PH_FIX32,
      PH_LEN,
      PH_SKIP,
      PH_DRAIN
   } phase_type;

   typedef enum logic [2:0] {
      KIND_FIELD,
      KIND_END,
      KIND_TRUNC,
      KIND_WIRE,
      KIND_LONG
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [31:0]             field_number;
      logic [2:0]              wire_type;
      logic [63:0]             field_value;
      logic [OffsetBits-1:0]   payload_offset;
      logic                    last_of_run;
   } result_type;

endpackage

### sv/protobuf_field_tokenizer.sv
// Channel  | Direction | Handshake           | Beat payload
// req      | in        | req_valid/req_stall | data_byte, end_of_message
// rsp      | out       | rsp_valid/rsp_stall | kind, field number, wire type, value,
//          |           |                     | payload offset, last_of_run
//
// One byte per cycle while req_stall is low: each beat is parsed in the accepting
// cycle and its results (zero, one or two) land in a four-entry result queue the
// next cycle. A byte that ends a field and the message both yields two results;
// the queue drains one result per cycle while rsp_stall is low, so sustained rate is
// one byte per cycle. req_stall rises when fewer than two queue entries are free.
// Reset (synchronous, active high) returns the parser to expecting a key and
// empties the queue; no clearing pass is needed.
`include "protobuf_field_tokenizer_macros.svh"

module protobuf_field_tokenizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_end_of_message,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_result_kind,
   output logic [31:0]                    rsp_field_number,
   output logic [2:0]                     rsp_wire_type,
   output logic [63:0]                    rsp_field_value,
   output logic [pft_pkg::OffsetBits-1:0] rsp_payload_offset,
   output logic                           rsp_last_of_run
);

   localparam int PB = pft_pkg::OffsetBits;
   localparam int QB = pft_pkg::QueuePtrBits;

   // Parser state
   pft_pkg::phase_type phase_ff, phase_in;
   logic [63:0]        acc_ff, acc_in;
   logic [3:0]         gc_ff, gc_in;
   logic [31:0]        fnum_ff, fnum_in;
   logic [2:0]         wtype_ff, wtype_in;
   logic [PB-1:0]      skip_ff, skip_in;
   logic [PB-1:0]      pos_ff, pos_in;

   // Result queue
   pft_pkg::result_type q_ff [pft_pkg::QueueDepth];
   logic [QB-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QB-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QB:0]         cnt_ff, cnt_in;

   logic                accept;
   logic                pop;
   pft_pkg::result_type res_a, res_b, slot0, slot1;
   logic                res_a_vld, res_b_vld;
   logic [1:0]          n_push;

   // Step scratch values
   logic [3:0]          sh_grp;
   logic [5:0]          sh;
   logic [63:0]         var_acc;
   logic [63:0]         fix_acc;
   logic [3:0]          fix_need;
   logic [PB-1:0]       pos_next;
   logic [PB-1:0]       skip_dec;

   function automatic pft_pkg::result_type mk_res(
      input pft_pkg::kind_type kind,
      input logic [31:0]       fn,
      input logic [2:0]        wt,
      input logic [63:0]       val,
      input logic [PB-1:0]     off
   );
      pft_pkg::result_type r;
      r.kind           = kind;
      r.field_number   = fn;
      r.wire_type      = wt;
      r.field_value    = val;
      r.payload_offset = off;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = (cnt_ff > (QB+1)'(pft_pkg::QueueDepth - 2));

   // Per-byte parse step
   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      gc_in     = gc_ff;
      fnum_in   = fnum_ff;
      wtype_in  = wtype_ff;
      skip_in   = skip_ff;
      res_a_vld = 1'b0;
      res_b_vld = 1'b0;
      res_a     = mk_res(pft_pkg::KIND_FIELD, '0, '0, '0, '0);
      res_b     = mk_res(pft_pkg::KIND_FIELD, '0, '0, '0, '0);

      sh_grp   = (gc_ff > pft_pkg::VarintLastGroup) ? pft_pkg::VarintLastGroup : gc_ff;
      sh       = 6'({2'b00, sh_grp} * 6'd7);
      var_acc  = acc_ff | ({57'b0, req_data_byte[6:0]} << sh);
      fix_acc  = acc_ff | ({56'b0, req_data_byte} << {gc_ff[2:0], 3'b000});
      fix_need = (phase_ff == pft_pkg::PH_FIX64) ? 4'd8 : 4'd4;
      pos_next = pos_ff + PB'(1);
      skip_dec = (skip_ff != '0) ? skip_ff - PB'(1) : skip_ff;

      unique case (phase_ff)
         pft_pkg::PH_KEY, pft_pkg::PH_VARVAL, pft_pkg::PH_LEN: begin
            acc_in = var_acc;
            if (req_data_byte[7]) begin
               if (gc_ff >= pft_pkg::VarintLastGroup) begin
                  res_a_vld = 1'b1;
                  res_a     = mk_res(pft_pkg::KIND_LONG, '0, '0, '0, '0);
                  phase_in  = pft_pkg::PH_DRAIN;
               end else begin
                  gc_in = gc_ff + 4'd1;
               end
            end else begin
               acc_in = '0;
               gc_in  = '0;
               priority if (phase_ff == pft_pkg::PH_VARVAL) begin
                  res_a_vld = 1'b1;
                  res_a     = mk_res(pft_pkg::KIND_FIELD, fnum_ff, wtype_ff, var_acc, '0);
                  phase_in  = pft_pkg::PH_KEY;
               end else if (phase_ff == pft_pkg::PH_LEN) begin
                  priority if (var_acc[63:PB] != '0) begin
                     // length too large to address: treat as truncated
                     res_a_vld = 1'b1;
                     res_a     = mk_res(pft_pkg::KIND_TRUNC, '0, '0, '0, '0);
                     phase_in  = pft_pkg::PH_DRAIN;
                  end else if (var_acc == '0) begin
                     res_a_vld = 1'b1;
                     res_a     = mk_res(pft_pkg::KIND_FIELD, fnum_ff, wtype_ff, '0, pos_next);
                     phase_in  = pft_pkg::PH_KEY;
                  end else begin
                     acc_in   = var_acc;
                     skip_in  = var_acc[PB-1:0];
                     phase_in = pft_pkg::PH_SKIP;
                  end
               end else begin
                  // key done: split into field number and wire type
                  fnum_in  = var_acc[34:3];
                  wtype_in = var_acc[2:0];
                  unique case (var_acc[2:0])
                     pft_pkg::WT_VARINT: phase_in = pft_pkg::PH_VARVAL;
                     pft_pkg::WT_FIX64:  phase_in = pft_pkg::PH_FIX64;
                     pft_pkg::WT_LEN:    phase_in = pft_pkg::PH_LEN;
                     pft_pkg::WT_FIX32:  phase_in = pft_pkg::PH_FIX32;
                     default: begin
                        res_a_vld = 1'b1;
                        res_a     = mk_res(pft_pkg::KIND_WIRE, '0, '0, '0, '0);
                        phase_in  = pft_pkg::PH_DRAIN;
                     end
                  endcase
               end
            end
         end
         pft_pkg::PH_FIX64, pft_pkg::PH_FIX32: begin
            acc_in = fix_acc;
            gc_in  = gc_ff + 4'd1;
            if (gc_in >= fix_need) begin
               res_a_vld = 1'b1;
               res_a     = mk_res(pft_pkg::KIND_FIELD, fnum_ff, wtype_ff, fix_acc, '0);
               acc_in    = '0;
               gc_in     = '0;
               phase_in  = pft_pkg::PH_KEY;
            end
         end
         pft_pkg::PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               res_a_vld = 1'b1;
               res_a     = mk_res(pft_pkg::KIND_FIELD, fnum_ff, wtype_ff, acc_ff,
                                  pos_next - acc_ff[PB-1:0]);
               acc_in    = '0;
               phase_in  = pft_pkg::PH_KEY;
            end
         end
         pft_pkg::PH_DRAIN: begin
         end
         default: begin
            phase_in = pft_pkg::PH_KEY;
            acc_in   = '0;
            gc_in    = '0;
         end
      endcase

      pos_in = pos_next;

      // End of message: report and return to reset state
      if (req_end_of_message) begin
         if (phase_in == pft_pkg::PH_KEY && gc_in == '0) begin
            res_b_vld = 1'b1;
            res_b     = mk_res(pft_pkg::KIND_END, '0, '0, '0, '0);
         end else if (phase_in != pft_pkg::PH_DRAIN) begin
            res_b_vld = 1'b1;
            res_b     = mk_res(pft_pkg::KIND_TRUNC, '0, '0, '0, '0);
         end
         phase_in = pft_pkg::PH_KEY;
         acc_in   = '0;
         gc_in    = '0;
         fnum_in  = '0;
         wtype_in = '0;
         skip_in  = '0;
         pos_in   = '0;
      end
   end

   // Pack results into queue slots and mark the last of the run
   always_comb begin
      slot0  = res_a_vld ? res_a : res_b;
      slot1  = res_b;
      n_push = 2'(res_a_vld) + 2'(res_b_vld);
      if (n_push == 2'd2) begin
         slot1.last_of_run = 1'b1;
      end else begin
         slot0.last_of_run = 1'b1;
      end
   end

   // Queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + QB'(n_push);
         cnt_in    = cnt_in + (QB+1)'(n_push);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QB'(1);
         cnt_in    = cnt_in - (QB+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= pft_pkg::PH_KEY;
         acc_ff    <= '0;
         gc_ff     <= '0;
         fnum_ff   <= '0;
         wtype_ff  <= '0;
         skip_ff   <= '0;
         pos_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            gc_ff    <= gc_in;
            fnum_ff  <= fnum_in;
            wtype_ff <= wtype_in;
            skip_ff  <= skip_in;
            pos_ff   <= pos_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (accept && n_push != 2'd0) begin
         q_ff[wr_ptr_ff] <= slot0;
      end
      if (accept && n_push == 2'd2) begin
         q_ff[wr_ptr_ff + QB'(1)] <= slot1;
      end
   end

   // Result beat
   assign rsp_valid          = (cnt_ff != '0);
   assign rsp_result_kind    = q_ff[rd_ptr_ff].kind;
   assign rsp_field_number   = q_ff[rd_ptr_ff].field_number;
   assign rsp_wire_type      = q_ff[rd_ptr_ff].wire_type;
   assign rsp_field_value    = q_ff[rd_ptr_ff].field_value;
   assign rsp_payload_offset = q_ff[rd_ptr_ff].payload_offset;
   assign rsp_last_of_run    = q_ff[rd_ptr_ff].last_of_run;

   // Checks
   `PFT_ASSERT(a_queue_bound, (cnt_ff <= (QB+1)'(pft_pkg::QueueDepth)), "result queue overflow")
   `PFT_ASSERT(a_skip_nonzero,
      (phase_ff == pft_pkg::PH_SKIP) |-> (skip_ff != '0 && gc_ff == '0),
      "skip phase with nothing left to skip")
   `PFT_ASSERT(a_group_bound, (gc_ff <= pft_pkg::VarintLastGroup), "group count out of range")
   `PFT_ASSERT(a_nonfield_zero,
      (rsp_valid && rsp_result_kind != pft_pkg::KIND_FIELD) |->
         (rsp_field_number == '0 && rsp_field_value == '0 && rsp_payload_offset == '0),
      "event beat carries field data")
   `PFT_ASSERT(a_eom_resets,
      (accept && req_end_of_message) |=>
         (phase_ff == pft_pkg::PH_KEY && pos_ff == '0 && acc_ff == '0),
      "parser not reset after end of message")

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

   // Run limits
   localparam int CycleLimit   = 400000;
   localparam int RandomTarget = 950;
   localparam int NoiseBytes   = 120;
   localparam int TailBytes    = 100;

   // Wire types the tokenizer rejects
   localparam logic [2:0] WT_GROUP_START = 3'd3;
   localparam logic [2:0] WT_GROUP_END   = 3'd4;
   localparam logic [2:0] WT_RESERVED6   = 3'd6;
   localparam logic [2:0] WT_RESERVED7   = 3'd7;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [7:0]                     req_data_byte = 8'd0;
   logic                           req_end_of_message = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [2:0]                     rsp_result_kind;
   logic [31:0]                    rsp_field_number;
   logic [2:0]                     rsp_wire_type;
   logic [63:0]                    rsp_field_value;
   logic [pft_pkg::OffsetBits-1:0] rsp_payload_offset;
   logic                           rsp_last_of_run;

   protobuf_field_tokenizer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_field_number   (rsp_field_number),
      .rsp_wire_type      (rsp_wire_type),
      .rsp_field_value    (rsp_field_value),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   // Counters and flags
   int  cycle_count     = 0;
   int  mismatch_count  = 0;
   int  results_checked = 0;
   int  bytes_sent      = 0;
   int  useful_bytes    = 0;
   int  messages_sent   = 0;
   int  stall_left      = 0;
   bit  idle_on         = 1'b1;

   // Tokenizer state as predicted
   pft_pkg::phase_type             tok_phase  = pft_pkg::PH_KEY;
   logic [63:0]                    tok_acc    = '0;
   logic [3:0]                     tok_groups = '0;
   logic [31:0]                    tok_field  = '0;
   logic [2:0]                     tok_wire   = '0;
   logic [pft_pkg::OffsetBits-1:0] tok_skip   = '0;
   logic [pft_pkg::OffsetBits-1:0] tok_pos    = '0;

   pft_pkg::result_type expected_tokens[$];
   pft_pkg::result_type byte_tokens[$];
   pft_pkg::result_type seen_token;
   pft_pkg::result_type wanted_token;

   // Message under construction
   logic [7:0] msg[$];
   logic [2:0] bad_wire[4] = '{WT_GROUP_START, WT_GROUP_END, WT_RESERVED6, WT_RESERVED7};

   function automatic void flag_error(string text);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("ERROR: %s", text);
   endfunction

   function automatic void add_token(pft_pkg::kind_type kind, logic [31:0] fn, logic [2:0] wt,
                                     logic [63:0] val,
                                     logic [pft_pkg::OffsetBits-1:0] off);
      pft_pkg::result_type r;
      r.kind           = kind;
      r.field_number   = fn;
      r.wire_type      = wt;
      r.field_value    = val;
      r.payload_offset = off;
      r.last_of_run    = 1'b0;
      byte_tokens.insert(byte_tokens.size(), r);
   endfunction

   // Predict the tokens one accepted byte yields and queue them
   function automatic void predict_tokens(logic [7:0] b, logic eom);
      logic [63:0]                    word;
      logic [pft_pkg::OffsetBits-1:0] here;
      logic [3:0]                     need;
      pft_pkg::result_type            r;
      here = tok_pos;
      byte_tokens.delete();
      if (tok_phase != pft_pkg::PH_DRAIN)
         useful_bytes++;
      case (tok_phase)
         pft_pkg::PH_KEY, pft_pkg::PH_VARVAL, pft_pkg::PH_LEN: begin
            tok_acc = tok_acc | ({57'd0, b[6:0]} << (7 * tok_groups));
            if (b[7]) begin
               if (tok_groups >= pft_pkg::VarintLastGroup) begin
                  add_token(pft_pkg::KIND_LONG, '0, '0, '0, '0);
                  tok_phase = pft_pkg::PH_DRAIN;
               end else begin
                  tok_groups++;
               end
            end else begin
               word = tok_acc;
               tok_acc = '0;
               tok_groups = '0;
               if (tok_phase == pft_pkg::PH_VARVAL) begin
                  add_token(pft_pkg::KIND_FIELD, tok_field, tok_wire, word, '0);
                  tok_phase = pft_pkg::PH_KEY;
               end else if (tok_phase == pft_pkg::PH_LEN) begin
                  if (word[63:pft_pkg::OffsetBits] != '0) begin
                     // length too big to address: flagged as truncation
                     add_token(pft_pkg::KIND_TRUNC, '0, '0, '0, '0);
                     tok_phase = pft_pkg::PH_DRAIN;
                  end else if (word == '0) begin
                     add_token(pft_pkg::KIND_FIELD, tok_field, tok_wire, '0, here + 1'b1);
                     tok_phase = pft_pkg::PH_KEY;
                  end else begin
                     tok_acc = word;
                     tok_skip = word[pft_pkg::OffsetBits-1:0];
                     tok_phase = pft_pkg::PH_SKIP;
                  end
               end else begin
                  tok_field = word[34:3];
                  tok_wire = word[2:0];
                  case (tok_wire)
                     pft_pkg::WT_VARINT: tok_phase = pft_pkg::PH_VARVAL;
                     pft_pkg::WT_FIX64:  tok_phase = pft_pkg::PH_FIX64;
                     pft_pkg::WT_LEN:    tok_phase = pft_pkg::PH_LEN;
                     pft_pkg::WT_FIX32:  tok_phase = pft_pkg::PH_FIX32;
                     default: begin
                        add_token(pft_pkg::KIND_WIRE, '0, '0, '0, '0);
                        tok_phase = pft_pkg::PH_DRAIN;
                     end
                  endcase
               end
            end
         end
         pft_pkg::PH_FIX64, pft_pkg::PH_FIX32: begin
            need = (tok_phase == pft_pkg::PH_FIX64) ? 4'd8 : 4'd4;
            tok_acc = tok_acc | ({56'd0, b} << (8 * tok_groups[2:0]));
            tok_groups++;
            if (tok_groups >= need) begin
               add_token(pft_pkg::KIND_FIELD, tok_field, tok_wire, tok_acc, '0);
               tok_acc = '0;
               tok_groups = '0;
               tok_phase = pft_pkg::PH_KEY;
            end
         end
         pft_pkg::PH_SKIP: begin
            if (tok_skip != '0)
               tok_skip--;
            if (tok_skip == '0) begin
               add_token(pft_pkg::KIND_FIELD, tok_field, tok_wire, tok_acc,
                         here + 1'b1 - tok_acc[pft_pkg::OffsetBits-1:0]);
               tok_acc = '0;
               tok_phase = pft_pkg::PH_KEY;
            end
         end
         default: ;
      endcase
      tok_pos = here + 1'b1;

      // end mark: clean end at a field boundary, truncation otherwise, nothing while draining
      if (eom) begin
         if (tok_phase == pft_pkg::PH_KEY && tok_groups == '0)
            add_token(pft_pkg::KIND_END, '0, '0, '0, '0);
         else if (tok_phase != pft_pkg::PH_DRAIN)
            add_token(pft_pkg::KIND_TRUNC, '0, '0, '0, '0);
         tok_phase  = pft_pkg::PH_KEY;
         tok_acc    = '0;
         tok_groups = '0;
         tok_field  = '0;
         tok_wire   = '0;
         tok_skip   = '0;
         tok_pos    = '0;
      end

      foreach (byte_tokens[i]) begin
         r = byte_tokens[i];
         r.last_of_run = (i == byte_tokens.size() - 1);
         expected_tokens.insert(expected_tokens.size(), r);
      end
   endfunction

   // Message encoding helpers
   function automatic void append_byte(logic [7:0] b);
      msg.insert(msg.size(), b);
   endfunction

   function automatic void push_varint(logic [63:0] v);
      while (v > 64'd127) begin
         append_byte({1'b1, v[6:0]});
         v = v >> 7;
      end
      append_byte({1'b0, v[6:0]});
   endfunction

   function automatic void push_le(logic [63:0] v, int n);
      for (int i = 0; i < n; i++)
         append_byte(v[8*i +: 8]);
   endfunction

   function automatic void push_key(logic [31:0] fn, logic [2:0] wt, logic [28:0] high);
      push_varint({high, fn, wt});
   endfunction

   function automatic void push_noise(int n);
      for (int i = 0; i < n; i++)
         append_byte(8'($urandom_range(0, 255)));
   endfunction

   function automatic logic [63:0] random_value();
      int          n;
      logic [63:0] v;
      n = $urandom_range(0, 64);
      v = {$urandom, $urandom};
      if (n < 64)
         v = v & ((64'd1 << n) - 64'd1);
      return v;
   endfunction

   // One beat on the request channel, with an optional idle burst first
   task automatic send_byte(logic [7:0] b, logic eom);
      if (idle_on && $urandom_range(0, 11) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= b;
      req_end_of_message <= eom;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_tokens(b, eom);
      bytes_sent++;
      if (eom)
         messages_sent++;
   endtask

   // Send msg up to and including index stop, end mark on that byte
   task automatic send_frame(int stop);
      for (int i = 0; i <= stop; i++)
         send_byte(msg[i], i == stop);
      msg.delete();
   endtask

   // Mostly well-formed fields, sometimes an error, sometimes cut short
   task automatic send_random_message();
      int          nfields;
      int          pick;
      int          len;
      int          stop;
      bit          done;
      logic [31:0] fn;
      logic [28:0] high;
      logic [63:0] v;
      nfields = $urandom_range(1, 5);
      done = 1'b0;
      for (int f = 0; f < nfields && !done; f++) begin
         fn   = $urandom >> $urandom_range(0, 31);
         high = ($urandom_range(0, 9) == 0) ? 29'($urandom) : 29'd0;
         pick = $urandom_range(0, 99);
         if (pick < 28) begin
            push_key(fn, pft_pkg::WT_VARINT, high);
            push_varint(random_value());
         end else if (pick < 42) begin
            push_key(fn, pft_pkg::WT_FIX64, high);
            push_le({$urandom, $urandom}, 8);
         end else if (pick < 56) begin
            push_key(fn, pft_pkg::WT_FIX32, high);
            push_le({32'd0, $urandom}, 4);
         end else if (pick < 86) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 60) : $urandom_range(0, 4);
            push_key(fn, pft_pkg::WT_LEN, high);
            push_varint(64'(len));
            push_noise(len);
         end else if (pick < 91) begin
            push_key(fn, bad_wire[$urandom_range(0, 3)], high);
            push_noise($urandom_range(0, 3));
            done = 1'b1;
         end else if (pick < 95) begin
            // ten groups that all continue, as key, value or length
            case ($urandom_range(0, 2))
               0: push_key(fn, pft_pkg::WT_VARINT, high);
               1: push_key(fn, pft_pkg::WT_LEN, high);
               default: ;
            endcase
            for (int i = 0; i < 10; i++)
               append_byte(8'($urandom_range(0, 127)) | 8'h80);
            push_noise($urandom_range(0, 3));
            done = 1'b1;
         end else begin
            v = ({$urandom, $urandom} >> $urandom_range(0, 39)) |
                (64'd1 << $urandom_range(pft_pkg::OffsetBits, 63));
            push_key(fn, pft_pkg::WT_LEN, high);
            push_varint(v);
            push_noise($urandom_range(0, 3));
            done = 1'b1;
         end
      end
      stop = msg.size() - 1;
      if ($urandom_range(0, 6) == 0)
         stop = $urandom_range(0, msg.size() - 1);
      send_frame(stop);
   endtask

   // Varint, fixed32 and length-delimited fields, with byte extremes and an empty payload last
   task automatic test_field_kinds();
      push_key(32'd1, pft_pkg::WT_VARINT, '0);
      push_varint(64'd150);
      push_key(32'd3, pft_pkg::WT_FIX32, '0);
      push_le(64'hFFFF_FFFF, 4);
      push_key(32'd5, pft_pkg::WT_LEN, '0);
      push_varint(64'd1);
      append_byte(8'h00);
      push_key(32'd4, pft_pkg::WT_LEN, '0);
      push_varint(64'd0);
      send_frame(msg.size() - 1);
   endtask

   // Unsupported wire type, huge length, overlong varint, cut-off key
   task automatic test_error_cases();
      push_key(32'd1, WT_GROUP_START, '0);
      send_frame(msg.size() - 1);
      push_key(32'd4, pft_pkg::WT_LEN, '0);
      push_varint(64'd1 << pft_pkg::OffsetBits);
      append_byte(8'h00);
      send_frame(msg.size() - 1);
      for (int i = 0; i < 10; i++)
         append_byte(8'hFF);
      send_frame(msg.size() - 1);
      append_byte(8'h80);
      send_frame(0);
   endtask

   // Random messages; idling switched on and off per stretch
   task automatic test_random_messages();
      while (useful_bytes < RandomTarget) begin
         if ($urandom_range(0, 9) == 0)
            idle_on = ~idle_on;
         send_random_message();
      end
      idle_on = 1'b1;
   endtask

   // Raw bytes with scattered end marks
   task automatic test_byte_noise();
      for (int i = 0; i < NoiseBytes; i++)
         send_byte(8'($urandom_range(0, 255)),
                   ($urandom_range(0, 15) == 0) || (i == NoiseBytes - 1));
   endtask

   // Full rate on both sides to close the run
   task automatic test_back_to_back();
      int start;
      idle_on = 1'b0;
      start = bytes_sent;
      while (bytes_sent - start < TailBytes)
         send_random_message();
   endtask

   // Receiver stall bursts
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(1, 18) - 1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Compare each result beat with the oldest predicted token
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_token.kind           = pft_pkg::kind_type'(rsp_result_kind);
         seen_token.field_number   = rsp_field_number;
         seen_token.wire_type      = rsp_wire_type;
         seen_token.field_value    = rsp_field_value;
         seen_token.payload_offset = rsp_payload_offset;
         seen_token.last_of_run    = rsp_last_of_run;
         if (expected_tokens.size() == 0) begin
            flag_error($sformatf("result %0d not expected, kind %0d",
                                 results_checked, rsp_result_kind));
         end else begin
            wanted_token = expected_tokens.pop_front();
            if (seen_token !== wanted_token)
               flag_error($sformatf({"result %0d: kind %0d/%0d field %0h/%0h wire %0d/%0d ",
                                     "value %0h/%0h offset %0h/%0h last %0b/%0b (got/want)"},
                                    results_checked,
                                    seen_token.kind, wanted_token.kind,
                                    seen_token.field_number, wanted_token.field_number,
                                    seen_token.wire_type, wanted_token.wire_type,
                                    seen_token.field_value, wanted_token.field_value,
                                    seen_token.payload_offset, wanted_token.payload_offset,
                                    seen_token.last_of_run, wanted_token.last_of_run));
         end
         results_checked++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("protobuf_field_tokenizer test failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_kinds();
      test_error_cases();
      test_random_messages();
      test_byte_noise();
      test_back_to_back();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d bytes in %0d messages; checked %0d results", bytes_sent,
               messages_sent, results_checked);
      $display("Covered all field kinds, error drains, truncation and raw noise; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0)
         $display("protobuf_field_tokenizer test passed");
      else
         $display("protobuf_field_tokenizer test failed");
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/pft_pkg.sv
sv/protobuf_field_tokenizer.sv
test/testbench.sv
